// ----- rtl/sodt_pkg.sv -----
`default_nettype none

package sodt_pkg;

  localparam int unsigned DATA_W    = 16;
  localparam int unsigned FUNC_W    = 2;
  localparam int unsigned MAX_OUT_W = 15;
  localparam int unsigned CNT_OUT_W = 5;

  localparam logic [FUNC_W-1:0] FUNC_UPDATE = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_APPEND = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_EXEC
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic scan_issue;
    logic exec;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic empty;
    logic scan_last;
  } sts_t;

  function automatic logic signed [DATA_W-1:0] smin(input logic signed [DATA_W-1:0] a,
                                                    input logic signed [DATA_W-1:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic signed [DATA_W-1:0] smax(input logic signed [DATA_W-1:0] a,
                                                    input logic signed [DATA_W-1:0] b);
    return (a > b) ? a : b;
  endfunction

  function automatic logic signed [DATA_W-1:0] sat_add(input logic signed [DATA_W-1:0] a,
                                                       input logic signed [DATA_W-1:0] b);
    logic signed [DATA_W:0] s;
    s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
    if (s[DATA_W] != s[DATA_W-1]) begin
      return s[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end
    return s[DATA_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/sodt_ram.sv -----
`default_nettype none

module sodt_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ----- rtl/sodt_ctrl.sv -----
`default_nettype none

module sodt_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  output logic               busy,
  input  wire sodt_pkg::sts_t sts_i,
  output sodt_pkg::cmd_t     cmd_o
);

  sodt_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sodt_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      sodt_pkg::ST_IDLE: begin
        if (start) begin
          state_d = sts_i.empty ? sodt_pkg::ST_EXEC : sodt_pkg::ST_SCAN;
        end
      end
      sodt_pkg::ST_SCAN: begin
        if (sts_i.scan_last) begin
          state_d = sodt_pkg::ST_DRAIN;
        end
      end
      sodt_pkg::ST_DRAIN: state_d = sodt_pkg::ST_EXEC;
      sodt_pkg::ST_EXEC:  state_d = sodt_pkg::ST_IDLE;
      default:            state_d = sodt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.load       = (state_q == sodt_pkg::ST_IDLE) && start;
    cmd_o.scan_issue = (state_q == sodt_pkg::ST_SCAN);
    cmd_o.exec       = (state_q == sodt_pkg::ST_EXEC);
    busy             = (state_q != sodt_pkg::ST_IDLE);
  end

endmodule

`default_nettype wire

// ----- rtl/sodt_dp.sv -----
`default_nettype none

module sodt_dp #(
  parameter int unsigned MAX_ENTRIES = 16
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire sodt_pkg::cmd_t                        cmd_i,
  output sodt_pkg::sts_t                             sts_o,
  input  wire logic        [sodt_pkg::FUNC_W-1:0]    func_i,
  input  wire logic signed [sodt_pkg::DATA_W-1:0]    offset_i,
  input  wire logic signed [sodt_pkg::DATA_W-1:0]    delta_i,
  output logic                                       valid_o,
  output logic signed      [sodt_pkg::DATA_W-1:0]    value_o,
  output logic signed      [sodt_pkg::DATA_W-1:0]    min_offset_o,
  output logic             [sodt_pkg::MAX_OUT_W-1:0] max_offset_o,
  output logic             [sodt_pkg::CNT_OUT_W-1:0] entry_count_o,
  output logic                                       overflow_o
);

  localparam int unsigned IW = $clog2(MAX_ENTRIES);
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned DW = sodt_pkg::DATA_W;

  // latched transaction
  logic        [sodt_pkg::FUNC_W-1:0] func_q;
  logic signed [DW-1:0]               off_q, delta_q;

  logic [CW-1:0] count_q, count_d;
  logic [IW-1:0] scan_idx_q, rd_idx_q;
  logic          issue_q;

  // scan results
  logic                 found_q;
  logic [IW-1:0]        match_idx_q;
  logic signed [DW-1:0] match_delta_q;
  logic signed [DW-1:0] last_off_q, last_delta_q;
  logic signed [DW-1:0] lo_all_q, hi_all_q, lo_ex_q, hi_ex_q;

  logic signed [DW-1:0] rd_off, rd_delta;
  logic                 is_match;

  // write side
  logic                 we_off, we_delta;
  logic [IW-1:0]        waddr;
  logic signed [DW-1:0] wdata_off, wdata_delta;

  // exec decision
  logic                 full, remove, accum, append;
  logic signed [DW-1:0] sum, value_d, lo_d, hi_d;
  logic                 ovf_d;
  logic [CW+sodt_pkg::CNT_OUT_W-1:0] count_ext;

  sodt_ram #(.WIDTH(DW), .DEPTH(MAX_ENTRIES)) u_off_ram (
    .clk_i   (clk_i),
    .we_i    (we_off),
    .waddr_i (waddr),
    .wdata_i (wdata_off),
    .raddr_i (scan_idx_q),
    .rdata_o (rd_off)
  );

  sodt_ram #(.WIDTH(DW), .DEPTH(MAX_ENTRIES)) u_delta_ram (
    .clk_i   (clk_i),
    .we_i    (we_delta),
    .waddr_i (waddr),
    .wdata_i (wdata_delta),
    .raddr_i (scan_idx_q),
    .rdata_o (rd_delta)
  );

  assign sts_o.empty     = (count_q == '0);
  assign sts_o.scan_last = ((CW'(scan_idx_q) + CW'(1)) == count_q);

  assign is_match = issue_q && !found_q && (rd_off == off_q);

  always_comb begin
    full    = (count_q == CW'(MAX_ENTRIES));
    sum     = sodt_pkg::sat_add(match_delta_q, delta_q);
    remove  = 1'b0;
    accum   = 1'b0;
    append  = 1'b0;
    ovf_d   = 1'b0;
    value_d = '0;
    case (func_q)
      sodt_pkg::FUNC_UPDATE: begin
        if (found_q) begin
          if (sum == '0) begin
            remove = 1'b1;
          end else begin
            accum   = 1'b1;
            value_d = sum;
          end
        end else if (full) begin
          ovf_d = 1'b1;
        end else if (delta_q != '0) begin
          append  = 1'b1;
          value_d = delta_q;
        end
      end
      sodt_pkg::FUNC_LOOKUP: begin
        value_d = found_q ? match_delta_q : '0;
      end
      sodt_pkg::FUNC_APPEND: begin
        if (full) begin
          ovf_d = 1'b1;
        end else begin
          append = 1'b1;
        end
        if (found_q) begin
          value_d = match_delta_q;
        end else if (!full) begin
          value_d = delta_q;
        end
      end
      default: value_d = '0;
    endcase

    count_d = count_q;
    if (remove) begin
      count_d = count_q - CW'(1);
    end else if (append) begin
      count_d = count_q + CW'(1);
    end

    // bounds: removal drops the matched entry, the moved last entry stays
    if (remove) begin
      lo_d = lo_ex_q;
      hi_d = hi_ex_q;
    end else if (append) begin
      lo_d = sodt_pkg::smin(lo_all_q, off_q);
      hi_d = sodt_pkg::smax(hi_all_q, off_q);
    end else begin
      lo_d = lo_all_q;
      hi_d = hi_all_q;
    end

    we_off      = cmd_i.exec && (remove || append);
    we_delta    = cmd_i.exec && (remove || append || accum);
    waddr       = append ? count_q[IW-1:0] : match_idx_q;
    wdata_off   = remove ? last_off_q : off_q;
    wdata_delta = remove ? last_delta_q : (accum ? sum : delta_q);
    count_ext   = {{sodt_pkg::CNT_OUT_W{1'b0}}, count_d};
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      scan_idx_q <= '0;
      issue_q    <= 1'b0;
      found_q    <= 1'b0;
      valid_o    <= 1'b0;
    end else begin
      issue_q <= cmd_i.scan_issue;
      valid_o <= cmd_i.exec;
      if (cmd_i.load) begin
        scan_idx_q <= '0;
        found_q    <= 1'b0;
      end else begin
        if (cmd_i.scan_issue) begin
          scan_idx_q <= scan_idx_q + IW'(1);
        end
        if (is_match) begin
          found_q <= 1'b1;
        end
      end
      if (cmd_i.exec) begin
        count_q <= count_d;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    rd_idx_q <= scan_idx_q;
    if (cmd_i.load) begin
      func_q   <= func_i;
      off_q    <= offset_i;
      delta_q  <= delta_i;
      lo_all_q <= '0;
      hi_all_q <= '0;
      lo_ex_q  <= '0;
      hi_ex_q  <= '0;
    end else if (issue_q) begin
      lo_all_q     <= sodt_pkg::smin(lo_all_q, rd_off);
      hi_all_q     <= sodt_pkg::smax(hi_all_q, rd_off);
      last_off_q   <= rd_off;
      last_delta_q <= rd_delta;
      if (is_match) begin
        match_idx_q   <= rd_idx_q;
        match_delta_q <= rd_delta;
      end else begin
        lo_ex_q <= sodt_pkg::smin(lo_ex_q, rd_off);
        hi_ex_q <= sodt_pkg::smax(hi_ex_q, rd_off);
      end
    end
    if (cmd_i.exec) begin
      value_o       <= value_d;
      min_offset_o  <= lo_d;
      max_offset_o  <= hi_d[sodt_pkg::MAX_OUT_W-1:0];
      entry_count_o <= count_ext[sodt_pkg::CNT_OUT_W-1:0];
      overflow_o    <= ovf_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/sparse_offset_delta_table_top.sv -----
// Channel   Ports                                        Transaction taken when
// -------   -------------------------------------------  ---------------------------
// command   start, func_i, offset_i, delta_i  / busy     start high, busy low
// result    valid_o, value_o, min_offset_o, max_offset_o, valid_o high (one cycle)
//           entry_count_o, overflow_o
//
// A command holds the block from acceptance to the next possible acceptance for a time
// set by the scan of the offset and delta memories, one entry per cycle on their single
// read port, so it grows with the entry count before it; an empty table skips the scan.
// The result strobe comes in the cycle after the write-back and the next command can be
// accepted in that same cycle. Reset clears the entry count and the sequencer; entries
// at or above the count are never read, so no clearing pass is run. The receiver cannot
// stall.
`default_nettype none

module sparse_offset_delta_table_top #(
  parameter int unsigned MAX_ENTRIES = 16
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  start,
  output logic                                       busy,
  input  wire logic        [sodt_pkg::FUNC_W-1:0]    func_i,
  input  wire logic signed [sodt_pkg::DATA_W-1:0]    offset_i,
  input  wire logic signed [sodt_pkg::DATA_W-1:0]    delta_i,
  output logic                                       valid_o,
  output logic signed      [sodt_pkg::DATA_W-1:0]    value_o,
  output logic signed      [sodt_pkg::DATA_W-1:0]    min_offset_o,
  output logic             [sodt_pkg::MAX_OUT_W-1:0] max_offset_o,
  output logic             [sodt_pkg::CNT_OUT_W-1:0] entry_count_o,
  output logic                                       overflow_o
);

  // command and status between sequencer and datapath
  sodt_pkg::cmd_t cmd;
  sodt_pkg::sts_t sts;

  // Sequencer: accept, scan the table and drain the last read unless empty, write back.
  sodt_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  // Datapath: holds the table memories, searches for the first match while tracking
  // the offset bounds with and without the matched entry, then updates, appends or
  // removes (last entry moves into the freed slot) and registers the result.
  sodt_dp #(.MAX_ENTRIES(MAX_ENTRIES)) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .func_i        (func_i),
    .offset_i      (offset_i),
    .delta_i       (delta_i),
    .valid_o       (valid_o),
    .value_o       (value_o),
    .min_offset_o  (min_offset_o),
    .max_offset_o  (max_offset_o),
    .entry_count_o (entry_count_o),
    .overflow_o    (overflow_o)
  );

endmodule

`default_nettype wire
